[rtl/rpbc_pkg.sv]
// Shared types and constants of the read path bundle classifier.
package rpbc_pkg;

    localparam int CFG_INDEX_W = 8;
    localparam int CFG_DATA_W  = 16;
    localparam int CAT_W       = 3;
    localparam int TOFF_W      = 4;
    localparam int COUNT_W     = 32;

    // Configuration register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_FIRST_NODE = 8'd0,
        REG_LAST_NODE  = 8'd1
    } cfg_reg_t;

    // Read categories as reported on the result channel
    typedef enum logic [CAT_W-1:0] {
        CAT_NONE   = 3'd0,
        CAT_SPAN   = 3'd1,
        CAT_BYPASS = 3'd2,
        CAT_UP     = 3'd3,
        CAT_DOWN   = 3'd4
    } cat_t;

    // Counter banks inside the count store
    typedef enum logic [1:0] {
        BANK_SPAN   = 2'd0,
        BANK_UP     = 2'd1,
        BANK_DOWN   = 2'd2,
        BANK_BYPASS = 2'd3
    } bank_t;

    // Classification request from the path tracker to the count store
    typedef struct packed {
        logic valid;
        cat_t category;
    } class_req_t;

endpackage

[rtl/rpbc_if.sv]
// Channel interfaces: path node input, result output and configuration write.
interface rpbc_node_if #(
    parameter int NODE_ID_BITS = 16
);
    logic                    valid;
    logic                    ready;
    logic [NODE_ID_BITS-1:0] node_id;
    logic                    path_end;

    modport source (output valid, output node_id, output path_end, input ready);
    modport sink   (input valid, input node_id, input path_end, output ready);
endinterface

interface rpbc_result_if;
    logic                                  valid;
    logic                                  ready;
    rpbc_pkg::cat_t                        category;
    logic [rpbc_pkg::TOFF_W-1:0]           target_offset;
    logic [rpbc_pkg::COUNT_W-1:0]          count_after;

    modport source (output valid, output category, output target_offset,
                    output count_after, input ready);
    modport sink   (input valid, input category, input target_offset,
                    input count_after, output ready);
endinterface

interface rpbc_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [rpbc_pkg::CFG_INDEX_W-1:0]    reg_index;
    logic [rpbc_pkg::CFG_DATA_W-1:0]     data;

    modport source (output valid, output reg_index, output data, input ready);
    modport sink   (input valid, input reg_index, input data, output ready);
endinterface

[rtl/read_path_bundle_classifier_unit.sv]
// Top level of the read path bundle classifier.
//
// Streams alignment path node ids, one item per cycle unless stalled, each
// with a mark on the last node of its path. Nodes below first_node count as
// upstream, nodes above the effective last node (last_node, clipped to
// MAX_BUNDLE_NODES nodes from first_node) as downstream, the rest as inside;
// the offset of the last inside node is kept. At path end the read is
// classified as spanning, bypassing, upstream flanking or downstream flanking
// (or left unclassified), the matching 32-bit counter saturates upward, and
// one result item carries category, offset and new count. Items that are not
// path ends give no result. The block accepts one item every cycle unless a
// stall on the result channel holds it back; a path-end item passes the input
// register, the counter read stage and the result register in that order. The
// counter memory's single read and write port with forwarding between
// back-to-back updates sets the one-per-cycle rate. Counters read as zero
// after reset through per-entry valid bits, so no clearing pass is needed.
// Write first_node (index 0) and last_node (index 1) only while the block is
// idle; other indexes are ignored.
module read_path_bundle_classifier_unit #(
    parameter int MAX_BUNDLE_NODES = 16,
    parameter int NODE_ID_BITS     = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    rpbc_cfg_if.sink       cfg,
    rpbc_node_if.sink      path_in,
    rpbc_result_if.source  result_out
);

    // Offset width: enough for every bundle position
    localparam int OFF_W = (MAX_BUNDLE_NODES > 1) ? $clog2(MAX_BUNDLE_NODES) : 1;

    logic [rpbc_pkg::CFG_DATA_W-1:0] first_node_reg;
    logic [rpbc_pkg::CFG_DATA_W-1:0] last_node_reg;

    rpbc_pkg::class_req_t req;
    logic [OFF_W-1:0]     req_offset;
    logic                 req_ready;

    // Configuration writes are always accepted: ready is tied high
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_node_reg <= '0;
            last_node_reg  <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.reg_index)
                rpbc_pkg::REG_FIRST_NODE: first_node_reg <= cfg.data;
                rpbc_pkg::REG_LAST_NODE:  last_node_reg  <= cfg.data;
                default:
                begin
                    // Drop writes to unknown indexes
                end
            endcase
        end
    end

    // Hold per-path flags and classify at path end
    rpbc_path_tracker #(
        .MAX_BUNDLE_NODES (MAX_BUNDLE_NODES),
        .NODE_ID_BITS     (NODE_ID_BITS),
        .OFF_W            (OFF_W)
    ) u_tracker (
        .clk         (clk),
        .rst_n       (rst_n),
        .first_node  (first_node_reg),
        .last_node   (last_node_reg),
        .in_valid    (path_in.valid),
        .in_ready    (path_in.ready),
        .in_node_id  (path_in.node_id),
        .in_path_end (path_in.path_end),
        .req         (req),
        .req_offset  (req_offset),
        .req_ready   (req_ready)
    );

    // Advance the matching counter and register the result item
    rpbc_count_store #(
        .OFF_W (OFF_W)
    ) u_store (
        .clk               (clk),
        .rst_n             (rst_n),
        .req               (req),
        .req_offset        (req_offset),
        .req_ready         (req_ready),
        .out_valid         (result_out.valid),
        .out_ready         (result_out.ready),
        .out_category      (result_out.category),
        .out_target_offset (result_out.target_offset),
        .out_count_after   (result_out.count_after)
    );

endmodule

[rtl/rpbc_path_tracker.sv]
// Input register, per-path flags and read classification.
module rpbc_path_tracker #(
    parameter int MAX_BUNDLE_NODES = 16,
    parameter int NODE_ID_BITS     = 16,
    parameter int OFF_W            = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [rpbc_pkg::CFG_DATA_W-1:0]     first_node,
    input  logic [rpbc_pkg::CFG_DATA_W-1:0]     last_node,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [NODE_ID_BITS-1:0]             in_node_id,
    input  logic                                in_path_end,
    output rpbc_pkg::class_req_t                req,
    output logic [OFF_W-1:0]                    req_offset,
    input  logic                                req_ready
);

    localparam int CMP_W = (NODE_ID_BITS > rpbc_pkg::CFG_DATA_W) ?
                           NODE_ID_BITS + 1 : rpbc_pkg::CFG_DATA_W + 1;

    logic                    s1_valid_reg;
    logic [NODE_ID_BITS-1:0] node_reg;
    logic                    end_reg;
    logic                    up_reg;
    logic                    down_reg;
    logic                    inside_reg;
    logic [OFF_W-1:0]        offset_reg;

    logic [CMP_W-1:0] node_ext;
    logic [CMP_W-1:0] first_ext;
    logic [CMP_W-1:0] last_ext;
    logic [CMP_W-1:0] cap;
    logic [CMP_W-1:0] last_eff;
    logic [CMP_W-1:0] diff;
    logic             is_up;
    logic             is_down;
    logic             is_inside;
    logic             up_fin;
    logic             down_fin;
    logic             inside_fin;
    logic [OFF_W-1:0] off_new;
    logic [OFF_W-1:0] off_fin;
    logic             s1_go;

    // Place the node against the bundle, clipped to the supported length
    always_comb
    begin
        node_ext   = CMP_W'(node_reg);
        first_ext  = CMP_W'(first_node);
        last_ext   = CMP_W'(last_node);
        cap        = first_ext + CMP_W'(MAX_BUNDLE_NODES - 1);
        last_eff   = (last_ext > cap) ? cap : last_ext;
        diff       = node_ext - first_ext;
        is_up      = node_ext < first_ext;
        is_down    = !is_up && (node_ext > last_eff);
        is_inside  = !is_up && !is_down;
        off_new    = OFF_W'(diff);
        up_fin     = up_reg | is_up;
        down_fin   = down_reg | is_down;
        inside_fin = inside_reg | is_inside;
        off_fin    = is_inside ? off_new : offset_reg;
    end

    // Classify at path end in priority order
    always_comb
    begin
        req.valid  = s1_valid_reg && end_reg;
        req.category = rpbc_pkg::CAT_NONE;
        req_offset = '0;
        if (up_fin && down_fin)
        begin
            if (inside_fin)
            begin
                req.category = rpbc_pkg::CAT_SPAN;
                req_offset   = off_fin;
            end
            else
            begin
                req.category = rpbc_pkg::CAT_BYPASS;
            end
        end
        else if (up_fin && inside_fin)
        begin
            req.category = rpbc_pkg::CAT_UP;
            req_offset   = off_fin;
        end
        else if (inside_fin && down_fin)
        begin
            req.category = rpbc_pkg::CAT_DOWN;
            req_offset   = off_fin;
        end
    end

    assign s1_go    = s1_valid_reg && (!end_reg || req_ready);
    assign in_ready = !s1_valid_reg || s1_go;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            up_reg       <= 1'b0;
            down_reg     <= 1'b0;
            inside_reg   <= 1'b0;
            offset_reg   <= '0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_go)
            begin
                // Clear flags at path end, else fold in this node
                if (end_reg)
                begin
                    up_reg     <= 1'b0;
                    down_reg   <= 1'b0;
                    inside_reg <= 1'b0;
                    offset_reg <= '0;
                end
                else
                begin
                    up_reg     <= up_fin;
                    down_reg   <= down_fin;
                    inside_reg <= inside_fin;
                    offset_reg <= off_fin;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            node_reg <= in_node_id;
            end_reg  <= in_path_end;
        end
    end

endmodule

[rtl/rpbc_count_store.sv]
// Saturating counter memory with read stage, forwarding and result register.
module rpbc_count_store #(
    parameter int OFF_W = 4
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  rpbc_pkg::class_req_t                req,
    input  logic [OFF_W-1:0]                    req_offset,
    output logic                                req_ready,
    output logic                                out_valid,
    input  logic                                out_ready,
    output rpbc_pkg::cat_t                      out_category,
    output logic [rpbc_pkg::TOFF_W-1:0]         out_target_offset,
    output logic [rpbc_pkg::COUNT_W-1:0]        out_count_after
);

    localparam int ADDR_W  = OFF_W + 2;
    localparam int ENTRIES = 1 << ADDR_W;

    logic [rpbc_pkg::COUNT_W-1:0] mem [ENTRIES];
    logic [ENTRIES-1:0]           entry_valid_reg;

    logic                         s2_valid_reg;
    rpbc_pkg::cat_t               s2_cat_reg;
    logic [OFF_W-1:0]             s2_off_reg;
    logic [ADDR_W-1:0]            s2_addr_reg;
    logic [rpbc_pkg::COUNT_W-1:0] rd_data_reg;
    logic                         rd_hit_reg;
    logic                         fwd_reg;

    logic                         out_valid_reg;
    rpbc_pkg::cat_t               out_cat_reg;
    logic [rpbc_pkg::TOFF_W-1:0]  out_off_reg;
    logic [rpbc_pkg::COUNT_W-1:0] out_count_reg;

    rpbc_pkg::bank_t              bank;
    logic [ADDR_W-1:0]            req_addr;
    logic                         req_fire;
    logic                         s2_go;
    logic                         s2_counted;
    logic [rpbc_pkg::COUNT_W-1:0] base;
    logic [rpbc_pkg::COUNT_W-1:0] count_next;

    always_comb
    begin
        case (req.category)
            rpbc_pkg::CAT_SPAN:   bank = rpbc_pkg::BANK_SPAN;
            rpbc_pkg::CAT_UP:     bank = rpbc_pkg::BANK_UP;
            rpbc_pkg::CAT_DOWN:   bank = rpbc_pkg::BANK_DOWN;
            default:              bank = rpbc_pkg::BANK_BYPASS;
        endcase
        req_addr = {bank, req_offset};
    end

    assign s2_go      = s2_valid_reg && (!out_valid_reg || out_ready);
    assign req_ready  = !s2_valid_reg || s2_go;
    assign req_fire   = req.valid && req_ready;
    assign s2_counted = (s2_cat_reg != rpbc_pkg::CAT_NONE);

    // Take the value just written by the item ahead when it hits the same counter
    always_comb
    begin
        if (fwd_reg)
        begin
            base = out_count_reg;
        end
        else if (rd_hit_reg)
        begin
            base = rd_data_reg;
        end
        else
        begin
            base = '0;
        end
        if (!s2_counted)
        begin
            count_next = '0;
        end
        else if (&base)
        begin
            count_next = base;
        end
        else
        begin
            count_next = base + rpbc_pkg::COUNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_go && s2_counted)
        begin
            mem[s2_addr_reg] <= count_next;
        end
        if (req_fire)
        begin
            rd_data_reg <= mem[req_addr];
            rd_hit_reg  <= entry_valid_reg[req_addr];
            fwd_reg     <= s2_valid_reg && s2_counted && (s2_addr_reg == req_addr);
            s2_cat_reg  <= req.category;
            s2_off_reg  <= req_offset;
            s2_addr_reg <= req_addr;
        end
        if (s2_go)
        begin
            out_cat_reg   <= s2_cat_reg;
            out_off_reg   <= rpbc_pkg::TOFF_W'(s2_off_reg);
            out_count_reg <= count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            entry_valid_reg <= '0;
            s2_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (s2_go && s2_counted)
            begin
                entry_valid_reg[s2_addr_reg] <= 1'b1;
            end
            if (req_ready)
            begin
                s2_valid_reg <= req.valid;
            end
            if (s2_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_category      = out_cat_reg;
    assign out_target_offset = out_off_reg;
    assign out_count_after   = out_count_reg;

endmodule

[bench/read_path_bundle_classifier_unit_test.sv]
`timescale 1ns / 1ps
// Testbench for read_path_bundle_classifier_unit: alignment paths checked against a read tally.
module read_path_bundle_classifier_unit_test;

    localparam int BUNDLE_SPAN     = 16;    // MAX_BUNDLE_NODES of the instance
    localparam int NODE_W          = 16;
    localparam int NODE_TOP        = (1 << NODE_W) - 1;
    localparam int GAP_MAX         = 16;
    localparam int SETTLE_CYCLES   = 8;     // margin for results still in flight
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int ITEMS_PER_PHASE = 85;
    localparam int PRINT_LIMIT     = 50;
    // An index outside the register map; the block must ignore the write.
    localparam logic [rpbc_pkg::CFG_INDEX_W-1:0] SPARE_REG_INDEX = 8'd2;

    // Where a stimulus node falls relative to the target bundle
    typedef enum int { NODE_UP, NODE_IN, NODE_DOWN, NODE_EDGE, NODE_ANY } node_kind_t;

    // One classified read as it should appear on the result channel
    typedef struct packed {
        rpbc_pkg::cat_t                category;
        logic [rpbc_pkg::TOFF_W-1:0]   target_offset;
        logic [rpbc_pkg::COUNT_W-1:0]  count_after;
    } read_call_t;

    // Tracks the bundle setting, the running path flags and the read counters;
    // holds the classified reads still owed by the block.
    class bundle_tally;
        logic [NODE_W-1:0]             first_id;
        logic [NODE_W-1:0]             last_id;
        bit                            up_seen;
        bit                            down_seen;
        bit                            in_seen;
        logic [rpbc_pkg::TOFF_W-1:0]   in_offset;
        logic [rpbc_pkg::COUNT_W-1:0]  span_counts [BUNDLE_SPAN];
        logic [rpbc_pkg::COUNT_W-1:0]  up_counts [BUNDLE_SPAN];
        logic [rpbc_pkg::COUNT_W-1:0]  down_counts [BUNDLE_SPAN];
        logic [rpbc_pkg::COUNT_W-1:0]  bypass_total;
        read_call_t                    pending_calls [$];
        int unsigned                   failures;
        int unsigned                   cat_hits [5];

        function new();
            first_id = '0;
            last_id = '0;
            clear_path();
            foreach (span_counts[i])
            begin
                span_counts[i] = '0;
                up_counts[i] = '0;
                down_counts[i] = '0;
            end
            bypass_total = '0;
            failures = 0;
            foreach (cat_hits[i])
                cat_hits[i] = 0;
        endfunction

        function void clear_path();
            up_seen = 1'b0;
            down_seen = 1'b0;
            in_seen = 1'b0;
            in_offset = '0;
        endfunction

        function void set_register(logic [rpbc_pkg::CFG_INDEX_W-1:0] idx,
                                   logic [rpbc_pkg::CFG_DATA_W-1:0] value);
            if (idx == rpbc_pkg::REG_FIRST_NODE)
                first_id = value;
            else if (idx == rpbc_pkg::REG_LAST_NODE)
                last_id = value;
        endfunction

        // Last node that still counts as inside: last_id, clipped to the bundle limit
        function logic [NODE_W-1:0] bundle_end();
            logic [NODE_W:0] cap;
            cap = first_id + BUNDLE_SPAN - 1;
            return ({1'b0, last_id} > cap) ? cap[NODE_W-1:0] : last_id;
        endfunction

        function logic [rpbc_pkg::COUNT_W-1:0] bumped(logic [rpbc_pkg::COUNT_W-1:0] value);
            return (value == '1) ? value : value + 1'b1;
        endfunction

        function void classify_node(logic [NODE_W-1:0] node, bit end_mark);
            read_call_t call;
            if (node < first_id)
                up_seen = 1'b1;
            else if (node > bundle_end())
                down_seen = 1'b1;
            else
            begin
                in_seen = 1'b1;
                in_offset = rpbc_pkg::TOFF_W'(node - first_id);
            end
            if (!end_mark)
                return;
            call = '{rpbc_pkg::CAT_NONE, '0, '0};
            if (up_seen && down_seen)
            begin
                if (in_seen)
                begin
                    span_counts[in_offset] = bumped(span_counts[in_offset]);
                    call = '{rpbc_pkg::CAT_SPAN, in_offset, span_counts[in_offset]};
                end
                else
                begin
                    bypass_total = bumped(bypass_total);
                    call = '{rpbc_pkg::CAT_BYPASS, '0, bypass_total};
                end
            end
            else if (up_seen && in_seen)
            begin
                up_counts[in_offset] = bumped(up_counts[in_offset]);
                call = '{rpbc_pkg::CAT_UP, in_offset, up_counts[in_offset]};
            end
            else if (in_seen && down_seen)
            begin
                down_counts[in_offset] = bumped(down_counts[in_offset]);
                call = '{rpbc_pkg::CAT_DOWN, in_offset, down_counts[in_offset]};
            end
            pending_calls = {pending_calls, call};
            clear_path();
        endfunction

        task report(string what);
            failures++;
            if (failures <= PRINT_LIMIT)
                $display("MISMATCH at %0t: %s", $time, what);
        endtask

        task check_result(rpbc_pkg::cat_t category, logic [rpbc_pkg::TOFF_W-1:0] offset,
                          logic [rpbc_pkg::COUNT_W-1:0] count);
            read_call_t want;
            if (pending_calls.size() == 0)
            begin
                report($sformatf("result with no read pending: category %0d offset %0d count %0d",
                                 category, offset, count));
                return;
            end
            want = pending_calls.pop_front();
            cat_hits[int'(want.category)]++;
            if (category !== want.category)
                report($sformatf("category %0d, want %0d", category, want.category));
            if (offset !== want.target_offset)
                report($sformatf("target_offset %0d, want %0d", offset, want.target_offset));
            if (count !== want.count_after)
                report($sformatf("count_after %0d, want %0d", count, want.count_after));
        endtask
    endclass

    logic clk;
    logic rst_n;

    rpbc_node_if #(.NODE_ID_BITS(NODE_W)) path_if ();
    rpbc_result_if                        res_if ();
    rpbc_cfg_if                           cfg_if ();

    read_path_bundle_classifier_unit #(
        .MAX_BUNDLE_NODES (BUNDLE_SPAN),
        .NODE_ID_BITS     (NODE_W)
    ) i_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg_if),
        .path_in    (path_if),
        .result_out (res_if)
    );

    bundle_tally tally = new();

    // When set, that side runs without idle cycles for the current phase
    bit          sender_eager = 1'b0;
    bit          receiver_eager = 1'b0;
    int unsigned nodes_sent = 0;
    int unsigned paths_sent = 0;
    int unsigned settings_used = 0;
    int unsigned quiet_cycles = 0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Draw the idle cycles before the next item; at least a quarter of the items go without a gap.
    function automatic int unsigned pick_gap(bit eager);
        if (eager || $urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    // Draw a node id of the given kind under the current bundle setting. Fall back
    // to any id when the wanted range is empty (no room upstream, say).
    function automatic logic [NODE_W-1:0] pick_node(node_kind_t kind);
        int lo;
        int top;
        lo = tally.first_id;
        top = tally.bundle_end();
        case (kind)
            NODE_UP:
                if (lo > 0)
                    return NODE_W'($urandom_range(lo - 1, 0));
            NODE_IN:
                if (top >= lo)
                    return NODE_W'($urandom_range(top, lo));
            NODE_DOWN:
                if (top < NODE_TOP)
                    return NODE_W'($urandom_range(NODE_TOP, top + 1));
            NODE_EDGE:
                case ($urandom_range(0, 3))
                    0: return NODE_W'(lo - 1);
                    1: return NODE_W'(lo);
                    2: return NODE_W'(top);
                    default: return NODE_W'(top + 1);
                endcase
            default: ;
        endcase
        return NODE_W'($urandom_range(NODE_TOP, 0));
    endfunction

    // Drive one node item at the falling edge and hold it until the block takes it.
    task automatic send_node(logic [NODE_W-1:0] node, bit end_mark);
        int unsigned gap;
        gap = pick_gap(sender_eager);
        @(negedge clk);
        if (gap > 0)
        begin
            path_if.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        path_if.valid = 1'b1;
        path_if.node_id = node;
        path_if.path_end = end_mark;
        do @(posedge clk); while (!path_if.ready);
        tally.classify_node(node, end_mark);
        nodes_sent++;
        if (end_mark)
            paths_sent++;
    endtask

    task automatic send_path(node_kind_t kinds[$]);
        foreach (kinds[i])
            send_node(pick_node(kinds[i]), i == kinds.size() - 1);
    endtask

    // Build one path. Most paths aim at a category with random content; the rest
    // are single-class paths, boundary nodes and plain noise.
    task automatic random_path();
        node_kind_t  kinds[$];
        node_kind_t  pool[$];
        int unsigned extra;
        case ($urandom_range(0, 9))
            0, 1:    kinds = {NODE_UP, NODE_IN, NODE_DOWN};
            2:       kinds = {NODE_UP, NODE_DOWN};
            3, 4:    kinds = {NODE_UP, NODE_IN};
            5, 6:    kinds = {NODE_IN, NODE_DOWN};
            7:       kinds = {node_kind_t'($urandom_range(0, 2))};
            8:       kinds = {NODE_EDGE};
            default: kinds = {NODE_ANY};
        endcase
        pool = kinds;
        extra = $urandom_range(0, 4);
        repeat (extra) kinds = {kinds, pool[$urandom_range(0, pool.size() - 1)]};
        // Mix the order so the last inside node lands anywhere in the path
        kinds.shuffle();
        send_path(kinds);
    endtask

    task automatic write_reg(logic [rpbc_pkg::CFG_INDEX_W-1:0] idx,
                             logic [rpbc_pkg::CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.reg_index = idx;
        cfg_if.data = value;
        do @(posedge clk); while (!cfg_if.ready);
        tally.set_register(idx, value);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    // Hold off the sender until every owed read has come back, then let the
    // pipeline settle so no path item is still in flight.
    task automatic wait_idle();
        @(negedge clk);
        path_if.valid = 1'b0;
        while (tally.pending_calls.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Drain, load a new bundle, and redraw how busy each side is for the next phase.
    task automatic apply_setting(logic [rpbc_pkg::CFG_DATA_W-1:0] first_value,
                                 logic [rpbc_pkg::CFG_DATA_W-1:0] last_value);
        wait_idle();
        write_reg(rpbc_pkg::REG_FIRST_NODE, first_value);
        write_reg(rpbc_pkg::REG_LAST_NODE, last_value);
        settings_used++;
        sender_eager = ($urandom_range(0, 2) == 0);
        receiver_eager = ($urandom_range(0, 2) == 0);
    endtask

    // Send random paths; now and then pause the sender until all reads are back.
    task automatic run_phase();
        int unsigned start;
        start = nodes_sent;
        while (nodes_sent - start < ITEMS_PER_PHASE)
        begin
            random_path();
            if ($urandom_range(0, 15) == 0)
                wait_idle();
        end
    endtask

    // Result side: stall for a drawn number of cycles, then take one item and check it.
    initial
    begin : result_sink
        int unsigned gap;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = pick_gap(receiver_eager);
            if (gap > 0)
            begin
                @(negedge clk);
                res_if.ready = 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            @(negedge clk);
            res_if.ready = 1'b1;
            do @(posedge clk); while (!res_if.valid);
            tally.check_result(res_if.category, res_if.target_offset, res_if.count_after);
        end
    end

    // Watchdog: end the run when no channel has moved an item for too long.
    always @(posedge clk)
    begin
        if ((path_if.valid && path_if.ready) || (res_if.valid && res_if.ready) ||
            (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles, %0d reads still owed",
                     WATCHDOG_LIMIT, tally.pending_calls.size());
            $display("read_path_bundle_classifier_unit test failed");
            $finish;
        end
    end

    initial
    begin : stimulus
        int unsigned first_value;
        int unsigned last_value;
        rst_n = 1'b0;
        path_if.valid = 1'b0;
        path_if.node_id = '0;
        path_if.path_end = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.reg_index = rpbc_pkg::REG_FIRST_NODE;
        cfg_if.data = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset setting: the bundle is node 0 alone, so no node is upstream.
        // Poke the unmapped index first; it must leave the setting as it is.
        write_reg(SPARE_REG_INDEX, rpbc_pkg::CFG_DATA_W'($urandom_range(NODE_TOP, 0)));
        run_phase();

        // Directed paths around an eight-node bundle at 100..107
        apply_setting(16'd100, 16'd107);
        // single inside node: path ends unclassified
        send_node(16'd103, 1'b1);
        // spanning through the first bundle node, boundary neighbors on both sides
        send_node(16'd99, 1'b0);
        send_node(16'd100, 1'b0);
        send_node(16'd108, 1'b1);
        // spanning at the last bundle node, extreme ids around it
        send_node(16'd0, 1'b0);
        send_node(16'd107, 1'b0);
        send_node(16'hFFFF, 1'b1);
        // bypass with the extreme ids in reverse order
        send_node(16'hFFFF, 1'b0);
        send_node(16'd0, 1'b1);
        // upstream flank: the later inside node sets the offset
        send_node(16'd102, 1'b0);
        send_node(16'd50, 1'b0);
        send_node(16'd105, 1'b1);
        // downstream flank
        send_node(16'd100, 1'b0);
        send_node(16'd200, 1'b1);
        // lone upstream and lone downstream paths stay unclassified
        send_node(16'd99, 1'b1);
        send_node(16'd108, 1'b1);
        // a second span at offset 0 bumps the same counter
        send_node(16'd1, 1'b0);
        send_node(16'd100, 1'b0);
        send_node(16'd60000, 1'b1);
        run_phase();

        // Bundle longer than the limit: nodes past first + 15 are downstream
        apply_setting(16'd1000, 16'd1400);
        run_phase();
        // last below first: nothing is inside
        apply_setting(16'd5000, 16'd4000);
        run_phase();
        // bottom of the id space: no upstream room
        apply_setting(16'd0, 16'd15);
        run_phase();
        // top of the id space
        apply_setting(16'd65520, 16'hFFFF);
        run_phase();
        // single-node bundle at the top: no downstream room
        apply_setting(16'hFFFF, 16'hFFFF);
        run_phase();
        // widest request, clipped to 0..15
        apply_setting(16'd0, 16'hFFFF);
        run_phase();
        // fully reversed extremes
        apply_setting(16'hFFFF, 16'd0);
        run_phase();

        // Random bundles, mostly short, sometimes arbitrary
        repeat (3)
        begin
            first_value = $urandom_range(NODE_TOP, 0);
            if ($urandom_range(0, 3) == 0)
                last_value = $urandom_range(NODE_TOP, 0);
            else
                last_value = first_value + $urandom_range(0, 2 * BUNDLE_SPAN);
            if (last_value > NODE_TOP)
                last_value = NODE_TOP;
            apply_setting(rpbc_pkg::CFG_DATA_W'(first_value),
                          rpbc_pkg::CFG_DATA_W'(last_value));
            run_phase();
        end

        // Drain the last reads and give the block time to show any stray result
        wait_idle();

        $display("covered %0d nodes in %0d paths over %0d bundle settings",
                 nodes_sent, paths_sent, settings_used);
        $display({"reads: %0d unclassified, %0d spanning, %0d bypassing, ",
                  "%0d upstream, %0d downstream"},
                 tally.cat_hits[rpbc_pkg::CAT_NONE], tally.cat_hits[rpbc_pkg::CAT_SPAN],
                 tally.cat_hits[rpbc_pkg::CAT_BYPASS], tally.cat_hits[rpbc_pkg::CAT_UP],
                 tally.cat_hits[rpbc_pkg::CAT_DOWN]);
        if (tally.failures == 0)
            $display("read_path_bundle_classifier_unit test passed");
        else
            $display("read_path_bundle_classifier_unit test failed");
        $finish;
    end

endmodule
